FILE: hw/rtl/cps_pkg.sv
// Shared types, constants and helpers of the contact process site update core.
// Used by every module under hw/rtl except cps_ram; depends on nothing else.
package cps_pkg;

  localparam int ROWS       = 128;
  localparam int BLOCK_COLS = 128;
  localparam int BLOCKS     = 8;
  localparam int COLS       = BLOCKS * BLOCK_COLS + 4;
  localparam int DEPTH      = ROWS * COLS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ROW_W      = 7;
  localparam int COL_W      = 11;
  localparam int FRAC_W     = 16;
  localparam int BLK_W      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int P_W        = FRAC_W + 1 + BLK_W;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // order of the neighbour list used for the pair neighbours
  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_RIGHT = 2'd2;
  localparam logic [1:0] NB_LEFT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_PROB   = 2'd2;

  localparam logic [2:0] OC_NONE  = 3'd0;
  localparam logic [2:0] OC_COLON = 3'd1;
  localparam logic [2:0] OC_DIED  = 3'd2;
  localparam logic [2:0] OC_FACIL = 3'd3;
  localparam logic [2:0] OC_SKIP  = 3'd4;

  localparam logic [2:0] PAIR_LAST = 3'd5;
  localparam logic [2:0] PAIR_HALF = 3'd3;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_READ,
    CMD_WRITE,
    CMD_SKIP,
    CMD_SKIP_RD,
    CMD_UPDATE
  } cmd_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [FRAC_W-1:0] draw_main;
    logic [FRAC_W-1:0] draw_death;
    logic [1:0]        direction;
    logic [2:0]        pair_choice;
    logic              write_value;
  } cps_in_t;

  typedef struct packed {
    logic [2:0]       outcome;
    logic             site_value;
    logic [ROW_W-1:0] changed_row;
    logic [COL_W-1:0] changed_column;
  } cps_out_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  nrow;
    logic [COL_W-1:0]  ncol;
    logic [ROW_W-1:0]  prow;
    logic [COL_W-1:0]  pcol;
    logic [ADDR_W-1:0] site_addr;
    logic [ADDR_W-1:0] nbr_addr;
    logic [ADDR_W-1:0] pair_addr;
    logic              wv;
    logic              colonise;
    logic              facil;
    logic              die;
  } job_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              we;
    logic              wd;
  } ram_req_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    addr_of = ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
  endfunction

  function automatic logic [ROW_W-1:0] row_up(input logic [ROW_W-1:0] r);
    row_up = (r == '0) ? ROW_W'(ROWS - 1) : r - 1'b1;
  endfunction

  function automatic logic [ROW_W-1:0] row_down(input logic [ROW_W-1:0] r);
    row_down = (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
  endfunction

endpackage

FILE: hw/rtl/cps_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module cps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wd,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end else begin
      rd <= mem[addr];
    end
  end

endmodule

FILE: hw/rtl/cps_front.sv
// Front end: holds the configuration registers and classifies each word
// into a job for the back end. Depends on cps_pkg.
module cps_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cps_pkg::CFG_W-1:0]      cfg_data,
  input  cps_pkg::cps_in_t               in_data,
  output cps_pkg::job_t                  job
);
  import cps_pkg::*;

  logic [FRAC_W-1:0] p_start_r, p_step_r, q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_start_r <= 16'd15729;
      p_step_r  <= 16'd7;
      q_r       <= 16'd62259;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIRTH_START: p_start_r <= cfg_data;
        CFG_BIRTH_STEP:  p_step_r  <= cfg_data;
        CFG_PAIR_PROB:   q_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  logic             in_range, boundary;
  logic [ROW_W-1:0] nr, br, pr;
  logic [COL_W-1:0] nc, bc, pcl;
  logic [COL_W-1:0] blk_full;
  logic [BLK_W-1:0] blk;
  logic [P_W-1:0]   p;
  logic [P_W:0]     death_sum;
  logic [1:0]       excl1, excl2, excl, k, idx;
  logic [2:0]       pc;
  cmd_t             cmd;

  always_comb begin
    in_range = (int'(in_data.row) < ROWS) && (int'(in_data.column) < COLS);
    boundary = (in_data.column < COL_W'(2)) || (int'(in_data.column) >= COLS - 2);

    blk_full  = COL_W'((in_data.column - COL_W'(2)) / BLOCK_COLS);
    blk       = blk_full[BLK_W-1:0];
    p         = P_W'(p_start_r) + P_W'(blk) * P_W'(p_step_r);
    death_sum = (P_W+1)'(in_data.draw_death) + (P_W+1)'(p);

    nr = in_data.row;
    nc = in_data.column;
    case (in_data.direction)
      DIR_UP: begin
        nr = row_up(in_data.row);
        excl1 = NB_UP;
        excl2 = NB_DOWN;
      end
      DIR_DOWN: begin
        nr = row_down(in_data.row);
        excl1 = NB_DOWN;
        excl2 = NB_UP;
      end
      DIR_LEFT: begin
        nc = in_data.column - 1'b1;
        excl1 = NB_LEFT;
        excl2 = NB_RIGHT;
      end
      default: begin
        nc = in_data.column + 1'b1;
        excl1 = NB_RIGHT;
        excl2 = NB_LEFT;
      end
    endcase

    // first half of the pair list hangs off the site, second off the neighbour
    pc = (in_data.pair_choice > PAIR_LAST) ? PAIR_LAST : in_data.pair_choice;
    if (pc < PAIR_HALF) begin
      k    = pc[1:0];
      br   = in_data.row;
      bc   = in_data.column;
      excl = excl1;
    end else begin
      k    = 2'(pc - PAIR_HALF);
      br   = nr;
      bc   = nc;
      excl = excl2;
    end
    idx = (k >= excl) ? k + 2'd1 : k;

    pr  = br;
    pcl = bc;
    case (idx)
      NB_UP:    pr  = row_up(br);
      NB_DOWN:  pr  = row_down(br);
      NB_RIGHT: pcl = bc + 1'b1;
      default:  pcl = bc - 1'b1;
    endcase

    case (in_data.kind)
      KIND_READ:   cmd = in_range ? CMD_READ : CMD_NONE;
      KIND_WRITE:  cmd = in_range ? CMD_WRITE : CMD_NONE;
      KIND_UPDATE: cmd = !in_range ? CMD_SKIP : (boundary ? CMD_SKIP_RD : CMD_UPDATE);
      default:     cmd = CMD_NONE;
    endcase

    job.cmd       = cmd;
    job.row       = in_data.row;
    job.col       = in_data.column;
    job.nrow      = nr;
    job.ncol      = nc;
    job.prow      = pr;
    job.pcol      = pcl;
    job.site_addr = addr_of(in_data.row, in_data.column);
    job.nbr_addr  = addr_of(nr, nc);
    job.pair_addr = addr_of(pr, pcl);
    job.wv        = in_data.write_value;
    job.colonise  = P_W'(in_data.draw_main) < p;
    job.facil     = in_data.draw_main < q_r;
    job.die       = death_sum < (P_W+1)'(65536);
  end

endmodule

FILE: hw/rtl/cps_queue.sv
// Short job queue between front and back end.
// Depends on cps_pkg.
module cps_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cps_pkg::job_t din,
  input  logic          pop,
  output cps_pkg::job_t dout,
  output logic          empty,
  output logic          full
);
  import cps_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign dout  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

FILE: hw/rtl/cps_back.sv
// Back end: runs each job against the lattice RAM (for an update: read site, read
// neighbour, write at most one site) and registers the result. Depends on cps_pkg.
module cps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cps_pkg::job_t     job,
  input  logic              empty,
  output logic              pop,
  output cps_pkg::ram_req_t req,
  input  logic              ram_rd,
  output logic              out_valid,
  output cps_pkg::cps_out_t out_data
);
  import cps_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SITE = 3'b010,
    B_NBR  = 3'b100
  } bstate_t;

  bstate_t  state_r, state_nxt;
  job_t     cur_r, cur_nxt;
  logic     out_valid_r, out_valid_nxt;
  cps_out_t out_r, out_nxt;

  function automatic cps_out_t mk(input logic [2:0] oc, input logic sv,
                                  input logic [ROW_W-1:0] r,
                                  input logic [COL_W-1:0] c);
    cps_out_t o;
    o.outcome        = oc;
    o.site_value     = sv;
    o.changed_row    = r;
    o.changed_column = c;
    return o;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    pop           = 1'b0;
    req.addr      = cur_r.site_addr;
    req.we        = 1'b0;
    req.wd        = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (state_r)
      B_IDLE: begin
        if (!empty) begin
          pop     = 1'b1;
          cur_nxt = job;
          req.addr = job.site_addr;
          case (job.cmd)
            CMD_READ, CMD_SKIP_RD, CMD_UPDATE: state_nxt = B_SITE;
            CMD_WRITE: begin
              req.we        = 1'b1;
              req.wd        = job.wv;
              out_valid_nxt = 1'b1;
              out_nxt       = mk(OC_NONE, job.wv, job.row, job.col);
            end
            CMD_SKIP: begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk(OC_SKIP, 1'b0, '0, '0);
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk(OC_NONE, 1'b0, '0, '0);
            end
          endcase
        end
      end
      B_SITE: begin
        case (cur_r.cmd)
          CMD_READ: begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk(OC_NONE, ram_rd, '0, '0);
            state_nxt     = B_IDLE;
          end
          CMD_SKIP_RD: begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk(OC_SKIP, ram_rd, '0, '0);
            state_nxt     = B_IDLE;
          end
          default: begin
            if (!ram_rd) begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk(OC_NONE, 1'b0, '0, '0);
              state_nxt     = B_IDLE;
            end else begin
              req.addr  = cur_r.nbr_addr;
              state_nxt = B_NBR;
            end
          end
        endcase
      end
      B_NBR: begin
        out_valid_nxt = 1'b1;
        state_nxt     = B_IDLE;
        if (!ram_rd) begin
          req.we = 1'b1;
          if (cur_r.colonise) begin
            req.addr = cur_r.nbr_addr;
            req.wd   = 1'b1;
            out_nxt  = mk(OC_COLON, 1'b1, cur_r.nrow, cur_r.ncol);
          end else begin
            out_nxt  = mk(OC_DIED, 1'b0, cur_r.row, cur_r.col);
          end
        end else if (cur_r.facil) begin
          req.we   = 1'b1;
          req.addr = cur_r.pair_addr;
          req.wd   = 1'b1;
          out_nxt  = mk(OC_FACIL, 1'b1, cur_r.prow, cur_r.pcol);
        end else if (cur_r.die) begin
          req.we  = 1'b1;
          out_nxt = mk(OC_DIED, 1'b0, cur_r.row, cur_r.col);
        end else begin
          out_nxt = mk(OC_NONE, 1'b1, '0, '0);
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/contact_process_site_update_core.sv
// Contact process site update core: front end, two-word job queue, back end
// on a single-port lattice RAM. An update on an occupied site runs through the site read,
// the neighbour read and at most one write; reads, boundary skips and updates on an empty
// site end after the site read; writes and other words end in the idle state. Results
// cannot be held off by the receiver. Synchronous active-low reset clears queue, sequencer
// and strobe, reloads default probabilities.
module contact_process_site_update_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  cps_pkg::cps_in_t              in_data,
  output logic                          out_valid,
  output cps_pkg::cps_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [cps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cps_pkg::CFG_W-1:0]     cfg_data
);
  import cps_pkg::*;

  job_t     fe_job, q_job;
  logic     q_empty, q_full, q_pop, ram_rd;
  ram_req_t req;

  assign busy = q_full;

  cps_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_data(in_data), .job(fe_job)
  );

  cps_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(start && !q_full), .din(fe_job),
    .pop(q_pop), .dout(q_job), .empty(q_empty), .full(q_full)
  );

  cps_back u_back (
    .clk(clk), .rst_n(rst_n), .job(q_job), .empty(q_empty), .pop(q_pop),
    .req(req), .ram_rd(ram_rd), .out_valid(out_valid), .out_data(out_data)
  );

  cps_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_lattice (
    .clk(clk), .addr(req.addr), .we(req.we), .wd(req.wd), .rd(ram_rd)
  );

endmodule

FILE: hw/rtl/cps_checker.sv
// Port-level checks on the contact process site update core, bound to it.
// Depends on cps_pkg.
module cps_port_props (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input cps_pkg::cps_out_t out_data
);
  import cps_pkg::*;

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("strobe or busy set after reset");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.outcome <= OC_SKIP)
    else $error("outcome code out of range");

  a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OC_SKIP
      |-> out_data.changed_row == '0 && out_data.changed_column == '0)
    else $error("skipped word reports a changed site");

  a_value_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == OC_COLON || out_data.outcome == OC_FACIL)
      |-> out_data.site_value)
    else $error("birth reported with empty site");

  a_died_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OC_DIED |-> !out_data.site_value)
    else $error("death reported with occupied site");

endmodule

bind contact_process_site_update_core cps_port_props u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid), .out_data(out_data)
);
